/* src/dcp_pkg.sv */
package dcp_pkg;

    localparam int MOD_W = 16;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    localparam logic [MOD_W-1:0] MOD_MIN = 16'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_PROBE,
        ST_WALK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic clr_step;
        logic clr_end;
        logic scan_rd;
        logic scan_inc;
        logic walk_start;
        logic walk_step;
        logic res_bad;
        logic res_done;
    } t_cmd;

    typedef struct packed {
        logic start_req;
        logic mod_ok;
        logic session_ok;
        logic clr_last;
        logic scan_end;
        logic seen;
        logic walk_back;
    } t_sts;

endpackage

/* src/dcp_in_if.sv */
interface dcp_in_if import dcp_pkg::*;;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [MOD_W-1:0] modulus;

    modport source (output valid, output req_type, output modulus, input ready);
    modport sink (input valid, input req_type, input modulus, output ready);
endinterface

/* src/dcp_out_if.sv */
interface dcp_out_if import dcp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] cycle_leader;
    logic [MOD_W-1:0] cycle_length;
    logic [MOD_W-1:0] cycle_count;
    logic             done_res;
    logic             invalid;

    modport source (
        output valid, output cycle_leader, output cycle_length, output cycle_count,
        output done_res, output invalid, input ready
    );
    modport sink (
        input valid, input cycle_leader, input cycle_length, input cycle_count,
        input done_res, input invalid, output ready
    );
endinterface

/* src/dcp_controller.sv */
module dcp_controller import dcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.start_req) begin
                        if (i_sts.mod_ok) begin
                            n_state = ST_CLEAR;
                        end else begin
                            o_cmd.res_bad = 1'b1;
                            n_state       = ST_OUT;
                        end
                    end else if (i_sts.session_ok) begin
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.res_bad = 1'b1;
                        n_state       = ST_OUT;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.clr_end = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.res_done = 1'b1;
                    n_state        = ST_OUT;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_sts.seen) begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_back) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open together");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.start_req && i_sts.mod_ok) |=> (r_state == ST_CLEAR))
        else $error("valid start did not begin the map clear");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_sts.walk_back) |=> (r_state == ST_OUT))
        else $error("closed cycle did not produce a result");

    a_probe_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE && !i_sts.seen) |=> (r_state == ST_WALK))
        else $error("unvisited residue did not start a walk");

endmodule

/* src/dcp_datapath.sv */
module dcp_datapath import dcp_pkg::*; #(
    parameter int MAX_MODULUS = 65534
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_req_type,
    input  logic [MOD_W-1:0] i_modulus,
    output t_sts             o_sts,
    output logic [MOD_W-1:0] o_cycle_leader,
    output logic [MOD_W-1:0] o_cycle_length,
    output logic [MOD_W-1:0] o_cycle_count,
    output logic             o_done_res,
    output logic             o_invalid
);

    localparam int DEPTH = MAX_MODULUS + 1;
    localparam int AW = $clog2(DEPTH);
    localparam logic [MOD_W-1:0] MAX_N = MOD_W'(MAX_MODULUS);

    logic             r_map [0:DEPTH-1];
    logic             r_rd;
    logic [MOD_W-1:0] r_mod;
    logic [MOD_W-1:0] r_scan;
    logic [MOD_W-1:0] r_count;
    logic             r_session;
    logic [MOD_W-1:0] r_lead;
    logic [MOD_W-1:0] r_cur;
    logic [MOD_W-1:0] r_len;
    logic [MOD_W-1:0] r_res_lead;
    logic [MOD_W-1:0] r_res_len;
    logic [MOD_W-1:0] r_res_cnt;
    logic             r_res_done;
    logic             r_res_bad;

    logic [MOD_W:0]   w_dbl;
    logic [MOD_W:0]   w_red;
    logic [MOD_W-1:0] w_nxt;
    logic [MOD_W-1:0] w_mod_m1;

    // doubling modulo n by one compare and subtract
    assign w_dbl    = {r_cur, 1'b0};
    assign w_red    = w_dbl - {1'b0, r_mod};
    assign w_nxt    = (w_dbl >= {1'b0, r_mod}) ? w_red[MOD_W-1:0] : w_dbl[MOD_W-1:0];
    assign w_mod_m1 = r_mod - MOD_W'(1);

    always_comb begin
        o_sts.start_req  = (i_req_type == REQ_START);
        o_sts.mod_ok     = i_modulus[0] && (i_modulus >= MOD_MIN) && (i_modulus <= MAX_N);
        o_sts.session_ok = r_session;
        o_sts.clr_last   = (r_scan == w_mod_m1);
        o_sts.scan_end   = (r_scan >= r_mod);
        o_sts.seen       = r_rd;
        o_sts.walk_back  = (w_nxt == r_lead);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= '0;
            r_scan    <= '0;
            r_count   <= '0;
            r_session <= 1'b0;
        end else begin
            if (i_cmd.take && o_sts.start_req) begin
                if (o_sts.mod_ok) begin
                    r_mod     <= i_modulus;
                    r_scan    <= '0;
                    r_count   <= '0;
                    r_session <= 1'b1;
                end else begin
                    r_session <= 1'b0;
                end
            end
            if ((i_cmd.clr_step && !i_cmd.clr_end) || i_cmd.scan_inc) begin
                r_scan <= r_scan + MOD_W'(1);
            end
            if (i_cmd.clr_end) begin
                r_scan <= '0;
            end
            if (i_cmd.walk_step && o_sts.walk_back) begin
                r_scan  <= r_lead + MOD_W'(1);
                r_count <= r_count + MOD_W'(1);
            end
            if (i_cmd.res_done) begin
                r_scan <= r_mod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_lead <= r_scan;
            r_cur  <= r_scan;
            r_len  <= '0;
        end
        if (i_cmd.walk_step) begin
            r_cur <= w_nxt;
            r_len <= r_len + MOD_W'(1);
            if (o_sts.walk_back) begin
                r_res_lead <= r_lead;
                r_res_len  <= r_len + MOD_W'(1);
                r_res_cnt  <= r_count + MOD_W'(1);
                r_res_done <= 1'b0;
                r_res_bad  <= 1'b0;
            end
        end
        if (i_cmd.res_bad) begin
            r_res_lead <= '0;
            r_res_len  <= '0;
            r_res_cnt  <= '0;
            r_res_done <= 1'b0;
            r_res_bad  <= 1'b1;
        end
        if (i_cmd.res_done) begin
            r_res_lead <= '0;
            r_res_len  <= '0;
            r_res_cnt  <= r_count;
            r_res_done <= 1'b1;
            r_res_bad  <= 1'b0;
        end
    end

    // visited map, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_map[r_scan[AW-1:0]] <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_map[w_nxt[AW-1:0]] <= 1'b1;
        end
        if (i_cmd.scan_rd) begin
            r_rd <= r_map[r_scan[AW-1:0]];
        end
    end

    assign o_cycle_leader = r_res_lead;
    assign o_cycle_length = r_res_len;
    assign o_cycle_count  = r_res_cnt;
    assign o_done_res     = r_res_done;
    assign o_invalid      = r_res_bad;

    a_done_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_done |=> (r_scan == r_mod))
        else $error("scan pointer not parked at modulus after done");

endmodule

/* src/doubling_cycle_partition_unit.sv */
// Doubling-cycle partition of the residues of an odd modulus n under x -> 2x mod n.
// Input channel i_in: req_type start (with modulus) or next; one result per request.
// Output channel o_out: cycle_leader, cycle_length, cycle_count, done_res, invalid.
// One request is worked at a time; i_in.ready is high only while the block is idle.
// A valid start clears residues 0..n-1 of the visited map, one per cycle, then
// reports the first cycle like a next request.
// A report scans from the saved pointer, each visited residue passing a scan and a
// probe state for the registered map read, then walks the cycle, one doubling step
// per cycle per member.
// A bad modulus or a next without a session answers invalid straight from idle.
// The result is held in registers on o_out until o_out.ready; a stalled receiver
// holds the block, and no new request is taken until the result is delivered.
// Reset clears the session, so a next before any valid start answers invalid;
// the map needs no clearing pass after reset since every start clears it.
module doubling_cycle_partition_unit import dcp_pkg::*; #(
    parameter int MAX_MODULUS = 65534
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcp_in_if.sink    i_in,
    dcp_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    dcp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    dcp_datapath #(
        .MAX_MODULUS (MAX_MODULUS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_in.req_type),
        .i_modulus      (i_in.modulus),
        .o_sts          (w_sts),
        .o_cycle_leader (o_out.cycle_leader),
        .o_cycle_length (o_out.cycle_length),
        .o_cycle_count  (o_out.cycle_count),
        .o_done_res     (o_out.done_res),
        .o_invalid      (o_out.invalid)
    );

endmodule

/* verif/doubling_cycle_partition_unit_tb.sv */
`timescale 1ns / 1ps

module doubling_cycle_partition_unit_tb import dcp_pkg::*;;

    localparam int MAX_MODULUS   = 65534;
    localparam int MAP_DEPTH     = 65536;
    localparam int TAIL_ITEMS    = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 30;
    localparam int DRAIN_CYCLES  = 64;
    localparam int STALL_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 80;

    typedef struct packed {
        logic             req;
        logic [MOD_W-1:0] modulus;
    } t_partition_req;

    typedef struct packed {
        logic [MOD_W-1:0] leader;
        logic [MOD_W-1:0] len;
        logic [MOD_W-1:0] count;
        logic             done;
        logic             bad;
    } t_cycle_report;

    logic i_clk;
    logic i_rst_n;

    dcp_in_if  in_if ();
    dcp_out_if out_if ();

    doubling_cycle_partition_unit #(
        .MAX_MODULUS(MAX_MODULUS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_partition_req pending_requests[$];
    t_cycle_report  expected_reports[$];

    bit               visited_res [0:MAP_DEPTH-1];
    logic [MOD_W-1:0] live_modulus  = '0;
    logic [MOD_W-1:0] scan_from     = '0;
    logic [MOD_W-1:0] cycles_so_far = '0;
    logic             session_live  = 1'b0;

    int mismatches    = 0;
    int reports_seen  = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    bit pressure_done = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        $display("error at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // walk from the first unvisited residue, marking the whole cycle
    function automatic t_cycle_report walk_next_cycle();
        t_cycle_report r;
        int unsigned   a;
        int unsigned   lead;
        int unsigned   n;
        int unsigned   len;
        r = '0;
        n = 32'(live_modulus);
        a = 32'(scan_from);
        while (a < n && visited_res[a[MOD_W-1:0]])
            a++;
        if (a >= n) begin
            scan_from = live_modulus;
            r.count   = cycles_so_far;
            r.done    = 1'b1;
            return r;
        end
        lead = a;
        len  = 0;
        do begin
            a = (a * 2) % n;
            visited_res[a[MOD_W-1:0]] = 1'b1;
            len++;
        end while (a != lead && len < MAP_DEPTH);
        cycles_so_far = cycles_so_far + MOD_W'(1);
        scan_from     = MOD_W'(lead + 1);
        r.leader      = MOD_W'(lead);
        r.len         = MOD_W'(len);
        r.count       = cycles_so_far;
        return r;
    endfunction

    task automatic predict_cycle_report(input logic req, input logic [MOD_W-1:0] n);
        t_cycle_report r;
        r = '0;
        if (req == REQ_START) begin
            if (n[0] == 1'b0 || n < MOD_MIN || n > MAX_MODULUS) begin
                session_live = 1'b0;
                r.bad        = 1'b1;
            end else begin
                foreach (visited_res[i])
                    visited_res[i] = 1'b0;
                live_modulus  = n;
                scan_from     = '0;
                cycles_so_far = '0;
                session_live  = 1'b1;
                r = walk_next_cycle();
            end
        end else if (!session_live || live_modulus == '0) begin
            r.bad = 1'b1;
        end else begin
            r = walk_next_cycle();
        end
        expected_reports.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [MOD_W-1:0] got,
                                 input logic [MOD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_cycle_report();
        t_cycle_report want;
        reports_seen++;
        if (expected_reports.size() == 0) begin
            report_mismatch("result with no request outstanding");
        end else begin
            want = expected_reports.pop_front();
            compare_field("cycle_leader", out_if.cycle_leader, want.leader);
            compare_field("cycle_length", out_if.cycle_length, want.len);
            compare_field("cycle_count", out_if.cycle_count, want.count);
            compare_field("done_res", MOD_W'(out_if.done_res), MOD_W'(want.done));
            compare_field("invalid", MOD_W'(out_if.invalid), MOD_W'(want.bad));
        end
    endtask

    task automatic add_request(input logic req, input logic [MOD_W-1:0] n);
        t_partition_req item;
        item.req     = req;
        item.modulus = n;
        pending_requests.push_back(item);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_cycle_report(in_if.req_type, in_if.modulus);
                void'(pending_requests.pop_front());
                if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 6);
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    in_if.valid    <= 1'b1;
                    in_if.req_type <= pending_requests[0].req;
                    in_if.modulus  <= pending_requests[0].modulus;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_cycle_report();
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!pressure_done && reports_seen >= HOLD_AFTER) begin
                // long hold-off so the sender backs up
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned sel;
        int unsigned k;
        int unsigned n;
        int          target;

        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.req_type = REQ_START;
        in_if.modulus  = '0;
        out_if.ready   = 1'b0;

        // next with no session, then bad moduli
        add_request(REQ_NEXT, 16'hFFFF);
        add_request(REQ_START, 16'd0);
        add_request(REQ_START, 16'd1);
        add_request(REQ_START, 16'd2);
        add_request(REQ_START, 16'd3);
        add_request(REQ_START, 16'd4);
        add_request(REQ_START, 16'd65534);
        add_request(REQ_START, 16'd65535);
        add_request(REQ_NEXT, 16'd0);
        // smallest modulus, run past done
        add_request(REQ_START, 16'd5);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_START, 16'd7);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_NEXT, 16'd0);
        // restart mid-session with the largest odd modulus
        add_request(REQ_START, 16'd15);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_START, 16'd65533);
        add_request(REQ_NEXT, 16'd0);
        add_request(REQ_NEXT, 16'd0);

        target = pending_requests.size() + RANDOM_ITEMS;
        while (pending_requests.size() < target) begin
            sel = $urandom_range(0, 19);
            if (sel <= 13) begin
                n = $urandom_range(2, 40) * 2 + 1;
                add_request(REQ_START, MOD_W'(n));
                k = $urandom_range(1, 14);
                repeat (k) add_request(REQ_NEXT, MOD_W'($urandom));
            end else if (sel == 14) begin
                n = $urandom_range(2048, 32766) * 2 + 1;
                add_request(REQ_START, MOD_W'(n));
                k = $urandom_range(0, 2);
                repeat (k) add_request(REQ_NEXT, MOD_W'($urandom));
            end else if (sel <= 17) begin
                if ($urandom_range(0, 1) == 0)
                    n = $urandom_range(0, 32767) * 2;
                else
                    n = $urandom_range(0, 3);
                add_request(REQ_START, MOD_W'(n));
                k = $urandom_range(0, 3);
                repeat (k) add_request(REQ_NEXT, MOD_W'($urandom));
            end else begin
                k = $urandom_range(1, 3);
                repeat (k) add_request(REQ_NEXT, MOD_W'($urandom));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_requests.size() != 0 || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
src/dcp_pkg.sv
src/dcp_in_if.sv
src/dcp_out_if.sv
src/dcp_controller.sv
src/dcp_datapath.sv
src/doubling_cycle_partition_unit.sv
verif/doubling_cycle_partition_unit_tb.sv
